// ----- rtl/even_spacing_distributor_defines.svh -----
// Assertion macros shared by the even spacing distributor RTL
`ifndef EVEN_SPACING_DISTRIBUTOR_DEFINES_SVH
`define EVEN_SPACING_DISTRIBUTOR_DEFINES_SVH

// Checked on every clock edge outside reset
`define ESD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("even_spacing_distributor check failed");

// Checked on every clock edge, reset included
`define ESD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("even_spacing_distributor check failed");

`endif

// ----- rtl/esd_pkg.sv -----
// Package: widths and types shared by the even spacing distributor
package esd_pkg;

  localparam int SUM_W   = 25;  // min+max edge sum, signed
  localparam int EDGE_W  = 24;
  localparam int IDX_W   = 6;   // box index and rank
  localparam int CNT_W   = 7;   // box count, holds 64
  localparam int NUM_W   = 33;  // 2*rank*span + den
  localparam int DEN_W   = 7;   // 2*(n-1)
  localparam int SHIFT_W = 26;
  localparam int MIN_SPREAD = 3;

  // Box travelling down the cell row while the set loads
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        idx;
    logic [IDX_W-1:0]        rank;
  } token_t;

  // Contents of one cell
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        rank;
  } cell_data_t;

endpackage

// ----- rtl/even_spacing_distributor.sv -----
// Top level: loads a box set, ranks centres in a cell row, emits even-spacing shifts
//
//  channel  direction  handshake               payload
//  in       in         in_valid / in_stall     box edges, final_box
//  out      out        out_valid / out_stall   box_index, shift_x, shift_y, run_end
//  cfg      in         cfg_write_en            cfg_write_data (spread_axis)
//
// Loading takes one box per cycle; each box then walks the cell row, one cell a cycle.
// After the final box the row drains; then, for each box in turn, a multiply, the
// bit-serial divider and the output register produce its shift.
// Synchronous active-high reset clears control state; cell contents need none.
// Input is stalled from the final box until the last shift is registered on the output.
`include "even_spacing_distributor_defines.svh"
module even_spacing_distributor #(
  parameter int MAX_BOXES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic                                cfg_write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [esd_pkg::EDGE_W-1:0]   box_min_x,
  input  logic signed [esd_pkg::EDGE_W-1:0]   box_max_x,
  input  logic signed [esd_pkg::EDGE_W-1:0]   box_min_y,
  input  logic signed [esd_pkg::EDGE_W-1:0]   box_max_y,
  input  logic                                final_box,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [esd_pkg::IDX_W-1:0]           box_index,
  output logic signed [esd_pkg::SHIFT_W-1:0]  shift_x,
  output logic signed [esd_pkg::SHIFT_W-1:0]  shift_y,
  output logic                                run_end
);
  import esd_pkg::*;

  typedef enum logic [2:0] {ST_LOAD, ST_DRAIN, ST_MUL, ST_DIVST, ST_DIV, ST_OUT} state_t;

  state_t                  state;
  logic                    spread_axis;
  logic [CNT_W-1:0]        box_count;
  logic [CNT_W-1:0]        n_boxes;
  logic [CNT_W-1:0]        drain_cnt;
  logic [IDX_W-1:0]        emit_idx;
  logic signed [SUM_W-1:0] sum_min;
  logic signed [SUM_W-1:0] sum_max;
  logic [SUM_W+IDX_W-1:0]  prod;
  logic                    div_start;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quot;

  logic                    in_accept;
  logic                    room;
  logic signed [SUM_W-1:0] in_sum;
  logic [SUM_W-1:0]        span;
  logic [IDX_W-1:0]        den;
  logic [NUM_W-1:0]        div_num;
  logic                    out_free;
  logic                    last_item;
  logic signed [SUM_W+1:0] shift_full;
  logic signed [SHIFT_W-1:0] shift_val;
  logic                    cell_shift;

  token_t     tok   [0:MAX_BOXES];
  cell_data_t cdata [0:MAX_BOXES-1];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_axis <= 1'b0;
    end else if (cfg_write_en) begin
      spread_axis <= cfg_write_data;
    end
  end

  assign in_stall  = state != ST_LOAD;
  assign in_accept = in_valid && !in_stall;
  assign room      = box_count < CNT_W'(MAX_BOXES);
  assign in_sum    = spread_axis
                   ? {box_min_y[EDGE_W-1], box_min_y} + {box_max_y[EDGE_W-1], box_max_y}
                   : {box_min_x[EDGE_W-1], box_min_x} + {box_max_x[EDGE_W-1], box_max_x};

  // span and rounding terms
  assign span      = SUM_W'(sum_max - sum_min);
  assign den       = IDX_W'(n_boxes - CNT_W'(1));
  assign div_num   = NUM_W'({prod, 1'b0}) + NUM_W'(den);
  assign out_free  = !out_valid || !out_stall;
  assign last_item = {1'b0, emit_idx} == n_boxes - CNT_W'(1);
  assign cell_shift = (state == ST_OUT) && out_free;
  assign div_start = state == ST_DIVST;

  assign shift_full = {sum_min[SUM_W-1], sum_min[SUM_W-1], sum_min}
                    + (SUM_W+2)'(div_quot[SUM_W-1:0])
                    - {cdata[0].sum[SUM_W-1], cdata[0].sum[SUM_W-1], cdata[0].sum};
  assign shift_val  = (n_boxes >= CNT_W'(MIN_SPREAD)) ? shift_full[SHIFT_W-1:0] : '0;

  // cell row
  for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
    cell_data_t nb;
    if (k == MAX_BOXES - 1) begin : g_end
      assign nb = cdata[k];
    end else begin : g_mid
      assign nb = cdata[k+1];
    end
    esd_cell #(.POS(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1]),
      .shift   (cell_shift),
      .nb_data (nb),
      .data    (cdata[k])
    );
  end

  esd_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   ({den, 1'b0}),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer: load, drain the row, then one shift per box
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      box_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (room) begin
              box_count    <= box_count + CNT_W'(1);
            end
            if (final_box) begin
              n_boxes   <= room ? box_count + CNT_W'(1) : box_count;
              box_count <= '0;
              drain_cnt <= '0;
              emit_idx  <= '0;
              state     <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + CNT_W'(1);
          if (drain_cnt == CNT_W'(MAX_BOXES + 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:   state <= ST_DIVST;
        ST_DIVST: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            box_index <= emit_idx;
            shift_x   <= spread_axis ? '0 : shift_val;
            shift_y   <= spread_axis ? shift_val : '0;
            run_end   <= last_item;
            emit_idx  <= emit_idx + IDX_W'(1);
            state     <= last_item ? ST_LOAD : ST_MUL;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // token entering the row, running extremes and product
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= in_accept && room;
    end
    tok[0].sum  <= in_sum;
    tok[0].idx  <= box_count[IDX_W-1:0];
    tok[0].rank <= '0;
    if (in_accept && room) begin
      if (box_count == '0) begin
        sum_min <= in_sum;
        sum_max <= in_sum;
      end else begin
        if (in_sum < sum_min) sum_min <= in_sum;
        if (in_sum > sum_max) sum_max <= in_sum;
      end
    end
    if (state == ST_MUL) begin
      prod <= cdata[0].rank * span;
    end
  end

  `ESD_ASSERT(a_div_done_in_div, div_done |-> state == ST_DIV)
  `ESD_ASSERT(a_emit_in_range, (state == ST_OUT) |-> ({1'b0, emit_idx} < n_boxes))
  `ESD_ASSERT(a_last_returns_load,
              (state == ST_OUT && out_free && last_item) |=> (state == ST_LOAD && run_end))
  `ESD_ASSERT(a_no_load_tokens_late,
              (state == ST_MUL) |-> !tok[0].valid)

endmodule

// ----- rtl/esd_cell.sv -----
// One cell of the ranking row: holds one box and ranks passing boxes against it
module esd_cell #(
  parameter int POS = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  esd_pkg::token_t    tok_in,
  output esd_pkg::token_t    tok_out,
  input  logic               shift,
  input  esd_pkg::cell_data_t nb_data,
  output esd_pkg::cell_data_t data
);
  import esd_pkg::*;

  logic hit;
  logic tok_le;
  logic tok_lt;

  assign hit    = tok_in.valid && (tok_in.idx == POS[IDX_W-1:0]);
  assign tok_le = data.sum <= tok_in.sum;   // held box ranks below passing one
  assign tok_lt = tok_in.sum < data.sum;    // passing box ranks below held one

  // token moves one cell on, dies at its own cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid && !hit;
    end
    tok_out.sum  <= tok_in.sum;
    tok_out.idx  <= tok_in.idx;
    tok_out.rank <= tok_in.rank + IDX_W'(tok_le);
  end

  // cell contents: shift during emission, deposit or rank update during load
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= nb_data;
    end else if (hit) begin
      data.sum  <= tok_in.sum;
      data.rank <= tok_in.rank;
    end else if (tok_in.valid && tok_lt) begin
      data.rank <= data.rank + IDX_W'(1);
    end
  end

endmodule

// ----- rtl/esd_div.sv -----
// Restoring divider, one quotient bit per cycle
module esd_div #(
  parameter int NW = 33,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_sh;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [CW-1:0] steps;
  logic          busy;
  logic          fits;

  assign trial = {rem, num_sh[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // one step per cycle, MSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      steps  <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NW-2:0], 1'b0};
      rem    <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quot   <= {quot[NW-2:0], fits};
      steps  <= steps + CW'(1);
    end
  end

endmodule
